// File: rtl/tcsb_pkg.sv
package tcsb_pkg;

  localparam int ROWS    = 4;
  localparam int COLUMNS = 20;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic       scrolled;
    logic       wrap_pending;
    logic [4:0] cursor_col;
    logic [1:0] cursor_row;
  } result_t;

  // Rows are kept in a ring; base is the physical row shown at the top.
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
                                             input logic [RW-1:0] row);
    logic [RW:0] sum;
    sum = {1'b0, base} + {1'b0, row};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    return AW'(row) * AW'(COLUMNS) + AW'(col);
  endfunction

endpackage

// File: rtl/tcsb_text_ram.sv
module tcsb_text_ram (
  input  logic              clk,
  input  tcsb_pkg::mem_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [tcsb_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// File: rtl/tcsb_ctrl.sv
module tcsb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [7:0]         char_code,
  input  logic [1:0]         cell_row,
  input  logic [4:0]         cell_col,
  output tcsb_pkg::mem_req_t mem_req,
  input  logic [7:0]         mem_rdata,
  output logic               res_valid,
  input  logic               res_ready,
  output tcsb_pkg::result_t  res
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_RDWAIT = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  localparam logic [tcsb_pkg::RW-1:0] BOTTOM   = tcsb_pkg::RW'(tcsb_pkg::ROWS - 1);
  localparam logic [tcsb_pkg::CW-1:0] COL_LAST = tcsb_pkg::CW'(tcsb_pkg::COLUMNS - 1);
  localparam logic [tcsb_pkg::AW-1:0] ADDR_LAST = tcsb_pkg::AW'(tcsb_pkg::CELLS - 1);

  logic [2:0]                  state, state_next;
  logic [tcsb_pkg::RW-1:0]     base, base_next;
  logic [tcsb_pkg::RW-1:0]     line, line_next;
  logic [tcsb_pkg::CW-1:0]     col, col_next;
  logic                        pend, pend_next;
  logic                        scrolled, scrolled_next;
  logic [7:0]                  rd_char, rd_char_next;
  logic [7:0]                  code, code_next;
  logic                        is_clear, is_clear_next;
  logic [tcsb_pkg::AW-1:0]     sweep_addr, sweep_addr_next;
  logic [tcsb_pkg::AW-1:0]     sweep_last, sweep_last_next;
  logic                        out_valid, out_valid_next;
  tcsb_pkg::result_t           out, out_next;

  logic                        accept;
  logic                        adv_nl;
  logic [tcsb_pkg::RW-1:0]     line_adv;
  logic [tcsb_pkg::CW-1:0]     col_adv;
  logic                        pend_adv;
  logic                        rd_in_range;
  logic [tcsb_pkg::AW-1:0]     cursor_addr;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = out_valid;
  assign res       = out;

  assign rd_in_range = (32'(cell_row) < tcsb_pkg::ROWS) && (32'(cell_col) < tcsb_pkg::COLUMNS);
  assign cursor_addr = tcsb_pkg::cell_addr(tcsb_pkg::phys_row(base, line), col);

  // Cursor step after a printable byte or a newline.
  always_comb begin
    adv_nl   = (state == ST_IDLE) && (char_code == tcsb_pkg::NEWLINE_CODE);
    line_adv = line;
    col_adv  = col + tcsb_pkg::CW'(1);
    pend_adv = pend;
    if (adv_nl || col == COL_LAST) begin
      col_adv = '0;
      if (line == BOTTOM) begin
        pend_adv = 1'b1;
      end else begin
        line_adv = line + tcsb_pkg::RW'(1);
      end
    end
  end

  always_comb begin
    state_next      = state;
    base_next       = base;
    line_next       = line;
    col_next        = col;
    pend_next       = pend;
    scrolled_next   = scrolled;
    rd_char_next    = rd_char;
    code_next       = code;
    is_clear_next   = is_clear;
    sweep_addr_next = sweep_addr;
    sweep_last_next = sweep_last;
    out_valid_next  = out_valid;
    out_next        = out;
    mem_req         = '0;

    if (res_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_INIT, ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep_addr;
        mem_req.wdata = tcsb_pkg::SPACE_CODE;
        if (sweep_addr == sweep_last) begin
          if (state == ST_INIT) begin
            state_next = ST_IDLE;
          end else if (is_clear) begin
            base_next  = '0;
            line_next  = '0;
            col_next   = '0;
            pend_next  = 1'b0;
            state_next = ST_RESP;
          end else begin
            base_next     = tcsb_pkg::phys_row(base, tcsb_pkg::RW'(1));
            col_next      = '0;
            pend_next     = 1'b0;
            scrolled_next = 1'b1;
            state_next    = ST_WRITE;
          end
        end else begin
          sweep_addr_next = sweep_addr + tcsb_pkg::AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          scrolled_next = 1'b0;
          rd_char_next  = '0;
          code_next     = char_code;
          state_next    = ST_RESP;
          case (req_type)
            tcsb_pkg::REQ_PUT: begin
              if (char_code == tcsb_pkg::NEWLINE_CODE) begin
                line_next = line_adv;
                col_next  = col_adv;
                pend_next = pend_adv;
              end else if (pend) begin
                sweep_addr_next = tcsb_pkg::cell_addr(base, '0);
                sweep_last_next = tcsb_pkg::cell_addr(base, COL_LAST);
                is_clear_next   = 1'b0;
                state_next      = ST_FILL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cursor_addr;
                mem_req.wdata = char_code;
                line_next     = line_adv;
                col_next      = col_adv;
                pend_next     = pend_adv;
              end
            end
            tcsb_pkg::REQ_READ: begin
              if (rd_in_range) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = tcsb_pkg::cell_addr(
                    tcsb_pkg::phys_row(base, tcsb_pkg::RW'(cell_row)),
                    tcsb_pkg::CW'(cell_col));
                state_next    = ST_RDWAIT;
              end
            end
            tcsb_pkg::REQ_CLEAR: begin
              sweep_addr_next = '0;
              sweep_last_next = ADDR_LAST;
              is_clear_next   = 1'b1;
              state_next      = ST_FILL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cursor_addr;
        mem_req.wdata = code;
        line_next     = line_adv;
        col_next      = col_adv;
        pend_next     = pend_adv;
        state_next    = ST_RESP;
      end
      ST_RDWAIT: begin
        rd_char_next = mem_rdata;
        state_next   = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid || res_ready) begin
          out_next.cursor_row   = 2'(line);
          out_next.cursor_col   = 5'(col);
          out_next.wrap_pending = pend;
          out_next.scrolled     = scrolled;
          out_next.cell_char    = rd_char;
          out_valid_next        = 1'b1;
          state_next            = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      base       <= '0;
      line       <= '0;
      col        <= '0;
      pend       <= 1'b0;
      is_clear   <= 1'b1;
      sweep_addr <= '0;
      sweep_last <= ADDR_LAST;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      base       <= base_next;
      line       <= line_next;
      col        <= col_next;
      pend       <= pend_next;
      is_clear   <= is_clear_next;
      sweep_addr <= sweep_addr_next;
      sweep_last <= sweep_last_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scrolled <= scrolled_next;
    rd_char  <= rd_char_next;
    code     <= code_next;
    out      <= out_next;
  end

endmodule

// File: rtl/text_console_scroll_buffer_core.sv
// Text console store of ROWS x COLUMNS byte cells with a cursor and deferred
// wrap, held in one single-port-write RAM with a registered read.
// Rows live in a ring with a top-row pointer, so a scroll only blanks one
// row. A request is taken when the core is idle and gives one result
// transfer. Plain puts, newlines, unused codes and reads outside the store
// go straight to the result; other reads wait on the RAM read, a put that
// resolves a pending wrap blanks a row (one RAM write per cell of the
// blanked row) before it writes, and a clear writes one space per cell.
// After reset the core sweeps the whole RAM with spaces before it takes the
// first request. The output register lets the next request enter while the
// previous result still waits.
module text_console_scroll_buffer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // char_code[7:0], cell_row[9:8], cell_col[14:10]
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // cursor_row[1:0], cursor_col[6:2], wrap_pending[7],
                                // scrolled[8], cell_char[16:9]
);

  tcsb_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rdata;
  tcsb_pkg::result_t  res;

  tcsb_text_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  tcsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req_type  (s_tuser),
    .char_code (s_tdata[7:0]),
    .cell_row  (s_tdata[9:8]),
    .cell_col  (s_tdata[14:10]),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {7'd0, res.cell_char, res.scrolled, res.wrap_pending,
                    res.cursor_col, res.cursor_row};

endmodule
